// ----- hdl/dat_pkg.sv -----
// Package for the deadline alarm table: entry record, command codes and helpers.
// Used by dat_ctrl, dat_dpath and the top level; depends on nothing else.
`timescale 1ns / 1ps
package dat_pkg;

  localparam int MAX_FIRE = 16;
  localparam int DIV_BITS = 50;
  localparam logic [48:0] DL_MAX = 49'h0_FFFF_FFFF_FFFF;

  // Item modes.
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_WALL   = 2'd3;

  // One table entry.
  typedef struct packed {
    logic [7:0]  owner;
    logic [1:0]  atype;
    logic [46:0] trig;
    logic [48:0] dl;
    logic [31:0] iv;
    logic        is_clock;
    logic [7:0]  show;
    logic        done;
  } ent_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_TICK_START, CMD_RMV_STEP, CMD_SET_PREP,
    CMD_INS_STEP, CMD_SCAN_STEP, CMD_SHIFT_DN, CMD_DIV_START, CMD_DIV_STEP,
    CMD_DIV_FIN, CMD_RED_STEP, CMD_SORT_NEXT, CMD_SUM_START, CMD_SUM_STEP,
    CMD_EMIT_NEXT
  } cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic [1:0] mode;
    logic       rmv_end;
    logic       full;
    logic       ins_end;
    logic       scan_end;
    logic       scan_hit;
    logic       sd_end;
    logic       iv_nz;
    logic       div_end;
    logic       red_end;
    logic       sort_end;
    logic       sum_end;
    logic       emit_last;
  } st_t;

  // Elapsed deadline of a stored trigger: wall types subtract the offset.
  function automatic logic [48:0] derive(input logic [1:0] atype,
                                         input logic [46:0] trig,
                                         input logic [47:0] off);
    logic [48:0] t;
    t = {2'b00, trig};
    if (atype == 2'd0 || atype == 2'd1) return t - {off[47], off};
    return t;
  endfunction

endpackage

// ----- hdl/deadline_alarm_table.sv -----
// Top level of the deadline alarm table: ties the controller to the datapath.
// Depends on dat_pkg, dat_ctrl and dat_dpath.
//
// Use: one input channel (in_valid/in_ready) carries set, cancel, tick and
// wall-change items; one output channel (out_valid/out_ready) returns results.
// Set, cancel and wall change give one result; a tick gives one result per
// fired alarm (up to 16), or one empty result. The last result has last = 1.
// Every result carries the summary as it stands after the whole item.
// One item is taken at a time: in_ready is high only while the block is idle.
// The table sequencer moves or examines one entry a cycle. A cancel makes one
// compacting pass and a set adds an insertion; a wall change re-derives every
// deadline and re-sorts the table. A tick scans the table and, for each fired
// alarm, closes the gap and, for a repeating one, runs the bit-serial remainder
// unit and reinserts the alarm.
// Results stay on the port until taken; a stall on out_ready holds the block.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
module deadline_alarm_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  owner_id,
  input  logic [1:0]  alarm_type,
  input  logic [47:0] trigger_ms,
  input  logic [31:0] interval_ms,
  input  logic        alarm_clock,
  input  logic [7:0]  show_ref,
  input  logic [47:0] now_ms,
  input  logic [47:0] wall_offset_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired_valid,
  output logic [7:0]  fired_owner,
  output logic        last,
  output logic        wake_valid,
  output logic [48:0] wake_deadline_ms,
  output logic        other_valid,
  output logic [48:0] other_deadline_ms,
  output logic        clock_valid,
  output logic [46:0] clock_trigger_ms,
  output logic [7:0]  clock_show_ref,
  output logic        status
);
  import dat_pkg::*;

  cmd_t cmd;
  st_t  st;

  // Sequencer.
  dat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  // Table and arithmetic.
  dat_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk, .rst, .cmd, .st, .mode, .owner_id, .alarm_type, .trigger_ms,
    .interval_ms, .alarm_clock, .show_ref, .now_ms, .wall_offset_ms,
    .fired_valid, .fired_owner, .last, .wake_valid, .wake_deadline_ms,
    .other_valid, .other_deadline_ms, .clock_valid, .clock_trigger_ms,
    .clock_show_ref, .status
  );

endmodule

// ----- hdl/dat_ctrl.sv -----
// Controller state machine for the deadline alarm table.
// Depends on dat_pkg; drives commands into dat_dpath and reads its status.
`timescale 1ns / 1ps
module dat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dat_pkg::st_t  st,
  output dat_pkg::cmd_t cmd
);
  import dat_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_DISP = 16'h0002, S_RMV  = 16'h0004, S_SETC = 16'h0008,
    S_INS   = 16'h0010, S_SCAN = 16'h0020, S_REMV = 16'h0040, S_DIVS = 16'h0080,
    S_DIV   = 16'h0100, S_DIVF = 16'h0200, S_RED  = 16'h0400, S_SORT = 16'h0800,
    S_SUMI  = 16'h1000, S_SUM  = 16'h2000, S_EMIT = 16'h4000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  // Next state and command.
  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.mode)
          MODE_TICK: begin
            cmd = CMD_TICK_START;
            state_next = S_SCAN;
          end
          MODE_WALL: state_next = S_RED;
          default:   state_next = S_RMV;
        endcase
      end
      S_RMV: begin
        cmd = CMD_RMV_STEP;
        if (st.rmv_end) state_next = (st.mode == MODE_SET) ? S_SETC : S_SUMI;
      end
      S_SETC: begin
        cmd = CMD_SET_PREP;
        state_next = st.full ? S_SUMI : S_INS;
      end
      S_INS: begin
        cmd = CMD_INS_STEP;
        if (st.ins_end) begin
          case (st.mode)
            MODE_TICK: state_next = S_SCAN;
            MODE_WALL: state_next = S_SORT;
            default:   state_next = S_SUMI;
          endcase
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN_STEP;
        if (st.scan_end) state_next = S_SUMI;
        else if (st.scan_hit) state_next = S_REMV;
      end
      S_REMV: begin
        cmd = CMD_SHIFT_DN;
        if (st.sd_end) state_next = st.iv_nz ? S_DIVS : S_SCAN;
      end
      S_DIVS: begin
        cmd = CMD_DIV_START;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (st.div_end) state_next = S_DIVF;
      end
      S_DIVF: begin
        cmd = CMD_DIV_FIN;
        state_next = S_INS;
      end
      S_RED: begin
        cmd = CMD_RED_STEP;
        if (st.red_end) state_next = S_SORT;
      end
      S_SORT: begin
        cmd = CMD_SORT_NEXT;
        state_next = st.sort_end ? S_SUMI : S_INS;
      end
      S_SUMI: begin
        cmd = CMD_SUM_START;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd = CMD_SUM_STEP;
        if (st.sum_end) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd = CMD_EMIT_NEXT;
          if (st.emit_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- hdl/dat_dpath.sv -----
// Datapath of the deadline alarm table: entry store, scan pointers, remainder
// divider, summary and fired-owner buffer. Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  dat_pkg::cmd_t cmd,
  output dat_pkg::st_t  st,
  input  logic [1:0]    mode,
  input  logic [7:0]    owner_id,
  input  logic [1:0]    alarm_type,
  input  logic [47:0]   trigger_ms,
  input  logic [31:0]   interval_ms,
  input  logic          alarm_clock,
  input  logic [7:0]    show_ref,
  input  logic [47:0]   now_ms,
  input  logic [47:0]   wall_offset_ms,
  output logic          fired_valid,
  output logic [7:0]    fired_owner,
  output logic          last,
  output logic          wake_valid,
  output logic [48:0]   wake_deadline_ms,
  output logic          other_valid,
  output logic [48:0]   other_deadline_ms,
  output logic          clock_valid,
  output logic [46:0]   clock_trigger_ms,
  output logic [7:0]    clock_show_ref,
  output logic          status
);
  import dat_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ent_t        tbl [TABLE_DEPTH];
  logic [CW-1:0] count, ri, wi, j;
  ent_t        rec;
  logic [1:0]  it_mode;
  logic [7:0]  it_owner;
  logic [1:0]  it_type;
  logic [47:0] it_trig;
  logic [31:0] it_iv;
  logic        it_clk;
  logic [7:0]  it_show;
  logic [47:0] it_now;
  logic [47:0] it_off;
  logic [DIV_BITS-1:0] dq;
  logic [31:0] rem;
  logic [5:0]  dc;
  logic [7:0]  fo [MAX_FIRE];
  logic [4:0]  nf;
  logic [3:0]  k;

  logic [CW-1:0] jm1, wp1, rp1;
  ent_t        e_ri, e_jm1;
  logic        ins_move, due;
  logic [32:0] dtmp;
  logic [49:0] ndw;

  assign jm1   = j - CW'(1);
  assign wp1   = wi + CW'(1);
  assign rp1   = ri + CW'(1);
  assign e_ri  = tbl[ri[IW-1:0]];
  assign e_jm1 = tbl[jm1[IW-1:0]];

  // Insertion moves past equal deadlines for a new alarm, strictly greater when sorting.
  always_comb begin
    ins_move = 1'b0;
    if (j != '0) begin
      if (it_mode == MODE_WALL) ins_move = $signed(e_jm1.dl) > $signed(rec.dl);
      else ins_move = $signed(e_jm1.dl) >= $signed(rec.dl);
    end
  end

  assign due  = $signed({e_ri.dl[48], e_ri.dl}) <= $signed({2'b00, it_now});
  assign dtmp = {rem, dq[DIV_BITS-1]};
  assign ndw  = {2'b00, it_now} - {18'd0, rem} + {18'd0, rec.iv};

  // Status to the controller.
  always_comb begin
    st.mode      = it_mode;
    st.rmv_end   = (ri == count);
    st.full      = (count >= CW'(TABLE_DEPTH));
    st.ins_end   = !ins_move;
    st.scan_end  = (ri >= count) || (nf == 5'(MAX_FIRE));
    st.scan_hit  = !e_ri.done && due;
    st.sd_end    = (wp1 >= count);
    st.iv_nz     = (rec.iv != '0);
    st.div_end   = (dc == '0);
    st.red_end   = (ri == count);
    st.sort_end  = (ri >= count);
    st.sum_end   = (ri == count);
    st.emit_last = (nf == '0) || ({1'b0, k} == nf - 5'd1);
  end

  // Result payload.
  assign fired_valid = (nf != '0);
  assign fired_owner = (nf != '0) ? fo[k] : 8'd0;
  assign last        = st.emit_last;

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_RMV_STEP: if (ri == count) count <= wi;
        CMD_INS_STEP: if (!ins_move && it_mode != MODE_WALL) count <= count + CW'(1);
        CMD_SHIFT_DN: if (wp1 >= count) count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  // Table, pointers and working registers.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        it_mode  <= mode;
        it_owner <= owner_id;
        it_type  <= alarm_type;
        it_trig  <= trigger_ms;
        it_iv    <= interval_ms;
        it_clk   <= alarm_clock;
        it_show  <= show_ref;
        it_now   <= now_ms;
        it_off   <= wall_offset_ms;
        ri       <= '0;
        wi       <= '0;
        nf       <= '0;
        k        <= '0;
        status   <= 1'b0;
      end
      CMD_TICK_START: begin
        for (int n = 0; n < TABLE_DEPTH; n++) tbl[n].done <= 1'b0;
      end
      // Compact the table, skipping the owner's entries.
      CMD_RMV_STEP: begin
        if (ri != count) begin
          if (e_ri.owner != it_owner) begin
            tbl[wi[IW-1:0]] <= e_ri;
            wi <= wp1;
          end
          ri <= rp1;
        end
      end
      CMD_SET_PREP: begin
        if (count >= CW'(TABLE_DEPTH)) begin
          status <= 1'b1;
        end else begin
          rec.owner    <= it_owner;
          rec.atype    <= it_type;
          rec.trig     <= it_trig[47] ? 47'd0 : it_trig[46:0];
          rec.dl       <= derive(it_type, it_trig[47] ? 47'd0 : it_trig[46:0], it_off);
          rec.iv       <= it_iv;
          rec.is_clock <= it_clk;
          rec.show     <= it_show;
          rec.done     <= 1'b0;
          j            <= count;
        end
      end
      // One step of insertion: shift up or place the held record.
      CMD_INS_STEP: begin
        if (ins_move) begin
          tbl[j[IW-1:0]] <= e_jm1;
          j <= jm1;
        end else begin
          tbl[j[IW-1:0]] <= rec;
        end
      end
      // Look at one entry; a due one is taken out and reported.
      CMD_SCAN_STEP: begin
        if (!(ri >= count || nf == 5'(MAX_FIRE))) begin
          if (!e_ri.done && due) begin
            rec <= e_ri;
            fo[nf[3:0]] <= e_ri.owner;
            nf <= nf + 5'd1;
            wi <= ri;
          end else begin
            ri <= rp1;
          end
        end
      end
      CMD_SHIFT_DN: begin
        if (wp1 < count) begin
          tbl[wi[IW-1:0]] <= tbl[wp1[IW-1:0]];
          wi <= wp1;
        end
      end
      // Remainder of the lag by the interval, one bit per cycle.
      CMD_DIV_START: begin
        dq  <= {2'b00, it_now} - {rec.dl[48], rec.dl};
        rem <= '0;
        dc  <= 6'(DIV_BITS);
      end
      CMD_DIV_STEP: begin
        if (dc != '0) begin
          rem <= 32'((dtmp >= {1'b0, rec.iv}) ? dtmp - {1'b0, rec.iv} : dtmp);
          dq  <= dq << 1;
          dc  <= dc - 6'd1;
        end
      end
      CMD_DIV_FIN: begin
        rec.dl   <= ($signed(ndw) > $signed({1'b0, DL_MAX})) ? DL_MAX : ndw[48:0];
        rec.done <= 1'b1;
        j        <= count;
      end
      // Re-derive one deadline per cycle.
      CMD_RED_STEP: begin
        if (ri != count) begin
          tbl[ri[IW-1:0]].dl <= derive(e_ri.atype, e_ri.trig, it_off);
          ri <= rp1;
        end else begin
          ri <= CW'(1);
        end
      end
      CMD_SORT_NEXT: begin
        if (ri < count) begin
          rec <= e_ri;
          j   <= ri;
          ri  <= rp1;
        end
      end
      CMD_SUM_START: begin
        ri <= '0;
        wake_valid <= 1'b0;
        wake_deadline_ms <= '0;
        other_valid <= 1'b0;
        other_deadline_ms <= '0;
        clock_valid <= 1'b0;
        clock_trigger_ms <= '0;
        clock_show_ref <= '0;
      end
      // Fold one entry into the summary.
      CMD_SUM_STEP: begin
        if (ri != count) begin
          if (!e_ri.atype[0]) begin
            if (!wake_valid || $signed(e_ri.dl) < $signed(wake_deadline_ms)) begin
              wake_valid <= 1'b1;
              wake_deadline_ms <= e_ri.dl;
            end
          end else if (!other_valid || $signed(e_ri.dl) < $signed(other_deadline_ms)) begin
            other_valid <= 1'b1;
            other_deadline_ms <= e_ri.dl;
          end
          if (e_ri.is_clock && (!clock_valid || e_ri.trig < clock_trigger_ms)) begin
            clock_valid <= 1'b1;
            clock_trigger_ms <= e_ri.trig;
            clock_show_ref <= e_ri.show;
          end
          ri <= rp1;
        end
      end
      CMD_EMIT_NEXT: k <= k + 4'd1;
      default: ;
    endcase
  end

endmodule

// ----- hdl/dat_checker.sv -----
// Port-level checks for the deadline alarm table, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module dat_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic fired_valid,
  input logic last,
  input logic status
);

  // A result waits until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // No item is taken while results are pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while results pending");

  // An empty result is always the only one.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired_valid |-> last) else $error("empty result not last");

  // A dropped set never reports a fired alarm.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !fired_valid) else $error("status on fired result");

endmodule

bind deadline_alarm_table dat_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .fired_valid, .last, .status
);
